// ===== rtl/bsc_pkg.sv =====
// shared types and constants for the byte stream to can segmenter
`default_nettype none
package bsc_pkg;

   // data bytes carried by a full frame, used clamped to 1..8
   localparam int FRAME_PAYLOAD_BYTES = 8;
   localparam int FRAME_SIZE_CLAMPED  = (FRAME_PAYLOAD_BYTES < 1) ? 1 :
                                        (FRAME_PAYLOAD_BYTES > 8) ? 8 : FRAME_PAYLOAD_BYTES;
   localparam logic [3:0] FRAME_SIZE  = 4'(FRAME_SIZE_CLAMPED);

   typedef enum logic [1:0] {
      FRAME_NORMAL = 2'h0,
      FRAME_START  = 2'h1,
      FRAME_STOP   = 2'h2,
      FRAME_SMALL  = 2'h3
   } frame_kind_type;

   typedef enum logic [2:0] {
      PH_LEN_LO = 3'd0,
      PH_LEN_HI = 3'd1,
      PH_SRC_LO = 3'd2,
      PH_SRC_HI = 3'd3,
      PH_DATA   = 3'd4
   } phase_type;

   typedef struct packed {
      frame_kind_type frame_type;
      logic [7:0]     source_id;
      logic [3:0]     byte_count;
      logic [63:0]    frame_data;
   } result_type;

endpackage
`default_nettype wire

// ===== rtl/bsc_core.sv =====
// message parser and frame assembly, one byte per transfer
`default_nettype none
module bsc_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         in_byte,
   output logic                    push,
   output bsc_pkg::result_type     result
);

   bsc_pkg::phase_type phase_ff, phase_in;
   logic [15:0] length_ff, length_in;
   logic [7:0]  source_ff, source_in;
   logic [15:0] left_ff, left_in;
   logic [63:0] buffer_ff, buffer_in;
   logic [3:0]  fill_ff, fill_in;
   logic        first_ff, first_in;

   logic [63:0] buffer_ins;
   logic [3:0]  fill_inc;
   logic [15:0] left_dec;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         bsc_pkg::PH_LEN_HI: phase_in = bsc_pkg::PH_SRC_LO;
         bsc_pkg::PH_SRC_LO: phase_in = bsc_pkg::PH_SRC_HI;
         bsc_pkg::PH_SRC_HI: begin
            phase_in = (length_ff == 16'd0) ? bsc_pkg::PH_LEN_LO : bsc_pkg::PH_DATA;
         end
         bsc_pkg::PH_DATA: begin
            if (left_dec == 16'd0) phase_in = bsc_pkg::PH_LEN_LO;
         end
         default: phase_in = bsc_pkg::PH_LEN_HI;
      endcase
   end

   // byte lane insert at the current fill position
   always_comb begin
      buffer_ins = buffer_ff;
      for (int i = 0; i < 8; i++) begin
         if (fill_ff[2:0] == 3'(i)) buffer_ins[8*i +: 8] = buffer_ff[8*i +: 8] | in_byte;
      end
   end

   assign fill_inc = fill_ff + 4'd1;
   assign left_dec = left_ff - 16'd1;

   // datapath and frame output
   always_comb begin
      length_in = length_ff;
      source_in = source_ff;
      left_in   = left_ff;
      buffer_in = buffer_ff;
      fill_in   = fill_ff;
      first_in  = first_ff;
      push      = 1'b0;
      result.frame_type = bsc_pkg::FRAME_SMALL;
      result.source_id  = source_ff;
      result.byte_count = fill_inc;
      result.frame_data = buffer_ins;
      case (phase_ff)
         bsc_pkg::PH_LEN_HI: begin
            length_in = {in_byte, length_ff[7:0]} + 16'd2;
         end
         bsc_pkg::PH_SRC_LO: begin
            source_in = in_byte;
         end
         bsc_pkg::PH_SRC_HI: begin
            buffer_in = 64'd0;
            fill_in   = 4'd0;
            first_in  = 1'b1;
            left_in   = length_ff;
            if (length_ff == 16'd0) begin
               // empty payload gives an empty small frame
               push              = 1'b1;
               result.byte_count = 4'd0;
               result.frame_data = 64'd0;
            end
         end
         bsc_pkg::PH_DATA: begin
            buffer_in = buffer_ins;
            fill_in   = fill_inc;
            left_in   = left_dec;
            if (length_ff <= 16'(bsc_pkg::FRAME_SIZE)) begin
               push = (left_dec == 16'd0);
            end else if (left_dec == 16'd0) begin
               push              = 1'b1;
               first_in          = 1'b1;
               result.frame_type = bsc_pkg::FRAME_STOP;
            end else if (fill_inc >= bsc_pkg::FRAME_SIZE) begin
               push              = 1'b1;
               first_in          = 1'b0;
               result.frame_type = first_ff ? bsc_pkg::FRAME_START : bsc_pkg::FRAME_NORMAL;
            end
            if (push) begin
               buffer_in = 64'd0;
               fill_in   = 4'd0;
            end
         end
         default: begin
            length_in = {8'd0, in_byte};
         end
      endcase
      push = push & accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= bsc_pkg::PH_LEN_LO;
         length_ff <= 16'd0;
         source_ff <= 8'd0;
         left_ff   <= 16'd0;
         buffer_ff <= 64'd0;
         fill_ff   <= 4'd0;
         first_ff  <= 1'b1;
      end else if (accept) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         source_ff <= source_in;
         left_ff   <= left_in;
         buffer_ff <= buffer_in;
         fill_ff   <= fill_in;
         first_ff  <= first_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/bsc_out_buf.sv =====
// two-entry output register with skid slot
`default_nettype none
module bsc_out_buf (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire bsc_pkg::result_type push_data,
   output logic                     full,
   output logic                     out_valid,
   input  wire logic                out_stall,
   output bsc_pkg::result_type      out_data
);

   logic [1:0]          count_ff, count_in;
   bsc_pkg::result_type head_ff, head_in;
   bsc_pkg::result_type skid_ff, skid_in;
   logic                pop;

   assign pop       = (count_ff != 2'd0) && !out_stall;
   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = head_ff;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      skid_in  = skid_ff;
      case (count_ff)
         2'd0: begin
            if (push) begin
               head_in  = push_data;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_in = push_data;
            end else if (push) begin
               skid_in  = push_data;
               count_in = 2'd2;
            end else if (pop) begin
               count_in = 2'd0;
            end
         end
         2'd2: begin
            // input is stalled while both slots hold a frame
            if (pop) begin
               head_in  = skid_ff;
               count_in = 2'd1;
            end
         end
         default: count_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule
`default_nettype wire

// ===== rtl/byte_stream_to_can_segmenter.sv =====
// a frame is written to the output register, shown on rsp_valid, with its last byte
// throughput: one byte per cycle while req_stall is low; it rises only while both
// output slots are full; the parse state and frame assembly update once per byte
// reset (synchronous, active high) returns the parser to the length low byte
// and empties the output register; no clearing pass is needed
`default_nettype none
module byte_stream_to_can_segmenter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_frame_type,
   output logic [7:0]       rsp_source_id,
   output logic [3:0]       rsp_byte_count,
   output logic [63:0]      rsp_frame_data
);

   logic                accept;
   logic                push;
   logic                full;
   bsc_pkg::result_type result;
   bsc_pkg::result_type out_data;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   bsc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .push    (push),
      .result  (result)
   );

   bsc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_frame_type = out_data.frame_type;
   assign rsp_source_id  = out_data.source_id;
   assign rsp_byte_count = out_data.byte_count;
   assign rsp_frame_data = out_data.frame_data;

endmodule
`default_nettype wire

// ===== rtl/bsc_checker.sv =====
// port-level checks for the segmenter, bound to the top level
`default_nettype none
module bsc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [7:0]  req_in_byte,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_frame_type,
   input wire logic [7:0]  rsp_source_id,
   input wire logic [3:0]  rsp_byte_count,
   input wire logic [63:0] rsp_frame_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("frame shown right after reset");

   a_hold_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_type) &&
      $stable(rsp_source_id) && $stable(rsp_frame_data) && $stable(rsp_byte_count))
      else $error("stalled frame dropped or changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_in_byte))
      else $error("stalled byte dropped or changed");

   a_full_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_frame_type == bsc_pkg::FRAME_START ||
                    rsp_frame_type == bsc_pkg::FRAME_NORMAL)
      |-> rsp_byte_count == bsc_pkg::FRAME_SIZE)
      else $error("start or normal frame not full");

   a_stop_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_type == bsc_pkg::FRAME_STOP
      |-> rsp_byte_count != 4'd0 && rsp_byte_count <= bsc_pkg::FRAME_SIZE)
      else $error("stop frame byte count out of range");

endmodule

bind byte_stream_to_can_segmenter bsc_checker u_bsc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_in_byte    (req_in_byte),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_frame_type (rsp_frame_type),
   .rsp_source_id  (rsp_source_id),
   .rsp_byte_count (rsp_byte_count),
   .rsp_frame_data (rsp_frame_data)
);
`default_nettype wire
